// File: rtl/tfh_pkg.sv
// Package for the temporal FIR high-pass block: sizes, register indexes,
// controller state and command types. No dependencies.
package tfh_pkg;
  localparam int unsigned Taps        = 10;
  localparam int unsigned HistSlots   = Taps - 1;
  localparam int unsigned FramePixels = 16384;
  localparam int unsigned PosW        = (FramePixels > 1) ? $clog2(FramePixels) : 1;
  localparam int unsigned SlotW       = (HistSlots > 1) ? $clog2(HistSlots) : 1;
  localparam int unsigned TapW        = $clog2(Taps + 1);
  localparam int unsigned MemDepth    = HistSlots * FramePixels;
  localparam int unsigned AddrW       = $clog2(MemDepth);
  localparam int unsigned CoeffRegs   = 3;
  localparam int unsigned AccW        = 40;
  localparam logic [15:0] HistInit    = 16'd410;

  localparam logic [1:0] RegCoeff03  = 2'd0;
  localparam logic [1:0] RegCoeff47  = 2'd1;
  localparam logic [1:0] RegCoeff811 = 2'd2;

  typedef enum logic [5:0] {
    StClear  = 6'b000001,
    StIdle   = 6'b000010,
    StRead   = 6'b000100,
    StDrain  = 6'b001000,
    StFinish = 6'b010000,
    StOut    = 6'b100000
  } state_e;

  typedef struct packed {
    logic             clr_we;    // write init value at clear address
    logic [AddrW-1:0] clr_addr;
    logic             load;      // capture input pixel, start acc with tap 0 product
    logic             rd_en;     // issue history read
    logic [TapW-1:0]  rd_tap;    // tap being read (1..Taps-1)
    logic             mac_en;    // accumulate returned data
    logic [TapW-1:0]  mac_tap;
    logic             finish;    // write back, advance position, form result
  } cmd_t;

  function automatic logic [AddrW-1:0] hist_addr(logic [SlotW-1:0] slot,
                                                 logic [PosW-1:0] pos);
    hist_addr = AddrW'(slot) * AddrW'(FramePixels) + AddrW'(pos);
  endfunction
endpackage

// File: rtl/tfh_ram.sv
// Generic single-port RAM, registered read.
// No dependencies.
module tfh_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: rtl/tfh_ctrl.sv
// Controller for the temporal FIR high-pass block: clearing pass,
// per-tap read sequence and result handshake. Uses tfh_pkg.
module tfh_ctrl
  import tfh_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o
);
  state_e           state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [TapW-1:0]  tap_q, tap_d;
  logic             pend_q, pend_d;   // read data returns next cycle
  logic [TapW-1:0]  ptap_q, ptap_d;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    tap_d   = tap_q;
    pend_d  = 1'b0;
    ptap_d  = tap_q;
    cmd_o   = '0;
    cmd_o.clr_addr = clr_q;
    cmd_o.mac_en   = pend_q;
    cmd_o.mac_tap  = ptap_q;
    cmd_o.rd_tap   = tap_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      StClear: begin
        cmd_o.clr_we = 1'b1;
        clr_d = clr_q + AddrW'(1);
        if (clr_q == AddrW'(MemDepth - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          tap_d   = TapW'(1);
          state_d = StRead;
        end
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        pend_d = 1'b1;
        ptap_d = tap_q;
        tap_d  = tap_q + TapW'(1);
        if (tap_q == TapW'(Taps - 1)) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        // last tap accumulates here
        state_d = StFinish;
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      tap_q   <= '0;
      pend_q  <= 1'b0;
      ptap_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      tap_q   <= tap_d;
      pend_q  <= pend_d;
      ptap_q  <= ptap_d;
    end
  end
endmodule

// File: rtl/tfh_datapath.sv
// Datapath for the temporal FIR high-pass block: coefficients, history RAM,
// multiply-accumulate, rounding and saturation. Uses tfh_pkg and tfh_ram.
module tfh_datapath
  import tfh_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic signed [15:0] pixel_value_i,
  output logic signed [15:0] filtered_value_o,
  output logic               frame_end_o,
  output logic               saturated_o
);
  logic [63:0]        coeff_q [CoeffRegs];
  logic signed [15:0] pix_q;
  logic [PosW-1:0]    pos_q;
  logic [SlotW-1:0]   newest_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [15:0] res_q;
  logic               end_q, sat_q;

  function automatic logic signed [15:0] coeff_of(logic [TapW-1:0] k,
                                                  logic [63:0] c0, logic [63:0] c1,
                                                  logic [63:0] c2);
    logic [63:0] r;
    r = (k[TapW-1:2] == 0) ? c0 : (k[TapW-1:2] == 1) ? c1 :
        (k[TapW-1:2] == 2) ? c2 : 64'd0;
    coeff_of = $signed(r[16*k[1:0] +: 16]);
  endfunction

  // slot for tap k: newest - (k-1) modulo HistSlots
  logic [SlotW-1:0] rd_slot, old_slot;
  logic [SlotW:0]   diff;
  always_comb begin
    diff = {1'b0, newest_q} + (SlotW+1)'(HistSlots) - (SlotW+1)'(cmd_i.rd_tap - TapW'(1));
    rd_slot = (diff >= (SlotW+1)'(HistSlots)) ? SlotW'(diff - (SlotW+1)'(HistSlots))
                                             : SlotW'(diff);
    old_slot = (newest_q == SlotW'(HistSlots - 1)) ? '0 : newest_q + SlotW'(1);
  end

  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [15:0]      ram_wdata, ram_rdata;
  always_comb begin
    ram_we    = cmd_i.clr_we | cmd_i.finish;
    ram_wdata = cmd_i.clr_we ? HistInit : pix_q;
    if (cmd_i.clr_we) ram_addr = cmd_i.clr_addr;
    else if (cmd_i.finish) ram_addr = hist_addr(old_slot, pos_q);
    else ram_addr = hist_addr(rd_slot, pos_q);
  end

  tfh_ram #(.Width(16), .Depth(MemDepth)) u_hist (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (cmd_i.rd_en),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  logic signed [31:0]     prod, prod0;
  logic signed [AccW-1:0] sum, rnd;
  always_comb begin
    prod  = coeff_of(cmd_i.mac_tap, coeff_q[0], coeff_q[1], coeff_q[2]) *
            $signed(ram_rdata);
    prod0 = coeff_of('0, coeff_q[0], coeff_q[1], coeff_q[2]) * pixel_value_i;
    sum   = acc_q + AccW'(prod);
    rnd   = (acc_q + AccW'(8192)) >>> 14;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CoeffRegs; i++) coeff_q[i] <= '0;
      pos_q    <= '0;
      newest_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegCoeff03:  coeff_q[0] <= cfg_data_i;
          RegCoeff47:  coeff_q[1] <= cfg_data_i;
          RegCoeff811: coeff_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        if (pos_q == PosW'(FramePixels - 1)) begin
          pos_q    <= '0;
          newest_q <= old_slot;
        end else begin
          pos_q <= pos_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_q <= pixel_value_i;
      acc_q <= AccW'(prod0);
    end else if (cmd_i.mac_en) begin
      acc_q <= sum;
    end
    if (cmd_i.finish) begin
      end_q <= (pos_q == PosW'(FramePixels - 1));
      if (rnd > AccW'(32767)) begin
        res_q <= 16'sd32767;
        sat_q <= 1'b1;
      end else if (rnd < -AccW'(32768)) begin
        res_q <= -16'sd32768;
        sat_q <= 1'b1;
      end else begin
        res_q <= rnd[15:0];
        sat_q <= 1'b0;
      end
    end
  end

  assign filtered_value_o = res_q;
  assign frame_end_o      = end_q;
  assign saturated_o      = sat_q;
endmodule

// File: rtl/temporal_fir_highpass_pixels.sv
// Top level of the per-pixel temporal FIR high-pass filter.
// Uses tfh_pkg, tfh_ctrl and tfh_datapath.
//
// Usage:
//  - Input channel: pixel_value_i with in_valid_i / in_stall_o, raster order,
//    FramePixels items to a frame, signed Q4.12.
//  - Output channel: filtered_value_o, frame_end_o, saturated_o with
//    out_valid_o / out_stall_i; one result per item, in order.
//  - Config: cfg_valid_i / cfg_ready_o, cfg_index_i selects one of three
//    64-bit coefficient words (four Q2.14 taps each); other indexes ignored.
//    Write only while idle.
//  - One item at a time: after an item is taken come the Taps-1 history
//    reads through the single RAM port, then the last accumulate, then
//    rounding and write-back, then the result is valid. The input opens
//    again only once the result is taken; the single history RAM port and
//    the multiplier shared by the history taps set this pace.
//  - After reset a clearing pass writes 0.1 to every history entry, one a
//    cycle, HistSlots*FramePixels entries (147456); no item is taken till then.
//  - A stalled result holds; the next item waits until it is taken.
module temporal_fir_highpass_pixels
  import tfh_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] pixel_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] filtered_value_o,
  output logic               frame_end_o,
  output logic               saturated_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);
  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  tfh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  tfh_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .pixel_value_i   (pixel_value_i),
    .filtered_value_o(filtered_value_o),
    .frame_end_o     (frame_end_o),
    .saturated_o     (saturated_o)
  );
endmodule

// File: dv/temporal_fir_highpass_pixels_tb.sv
// Self-checking testbench for temporal_fir_highpass_pixels: directed table, then random
// pixel streams, checked against a per-pixel history predictor.
// Depends on tfh_pkg and the RTL top level only.
`timescale 1ns / 1ps

module temporal_fir_highpass_pixels_tb;
  import tfh_pkg::*;

  localparam logic [1:0] RegUnused = 2'd3;   // decodes to nothing
  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned SettleCycles = Taps + 6;

  typedef struct packed {
    logic signed [15:0] value;
    logic               fend;
    logic               sat;
  } fir_out_t;

  // directed row: tap 0..3 word to load first, pixel, optional typed result
  typedef struct packed {
    logic [63:0]        taps03;
    logic signed [15:0] pixel;
    logic               typed;
    logic signed [15:0] value;
    logic               sat;
  } row_t;

  logic               clk_i, rst_ni;
  logic               in_valid_i, in_stall_o;
  logic signed [15:0] pixel_value_i;
  logic               out_valid_o, out_stall_i;
  logic signed [15:0] filtered_value_o;
  logic               frame_end_o, saturated_o;
  logic               cfg_valid_i, cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [63:0]        cfg_data_i;

  temporal_fir_highpass_pixels DUT (.*);

  // predictor state: coefficient words and a ring of past frames
  logic [63:0]        coeff_words [CoeffRegs];
  logic signed [15:0] past_frames [HistSlots*FramePixels];
  int unsigned        next_pos, newest_slot;

  fir_out_t           pending_q[$];
  int                 errors;
  int unsigned        cycle_count;

  // sender and receiver pacing
  int unsigned        gap_max, burst_left, stall_pct;
  logic               hold_req;
  int unsigned        hold_left;

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  function automatic logic signed [15:0] tap_coeff(int unsigned k);
    return coeff_words[k/4][16*(k%4) +: 16];
  endfunction

  // Works out one result and updates the history as the block would
  function automatic fir_out_t fir_predict(logic signed [15:0] pix);
    fir_out_t    r;
    longint      acc, rnd;
    int unsigned slot, oldest;
    acc = longint'(tap_coeff(0)) * longint'(pix);
    for (int unsigned k = 1; k < Taps; k++) begin
      slot = (newest_slot + HistSlots - (k - 1)) % HistSlots;
      acc += longint'(tap_coeff(k)) * longint'(past_frames[slot*FramePixels + next_pos]);
    end
    rnd = (acc + 8192) >>> 14;   // halves go toward plus infinity
    r.sat = 1'b1;
    if (rnd > 32767) r.value = 16'sh7FFF;
    else if (rnd < -32768) r.value = -16'sh8000;
    else begin
      r.value = rnd[15:0];
      r.sat = 1'b0;
    end
    oldest = (newest_slot + 1) % HistSlots;
    past_frames[oldest*FramePixels + next_pos] = pix;
    r.fend = (next_pos == FramePixels - 1);
    if (r.fend) begin
      next_pos = 0;
      newest_slot = oldest;
    end else begin
      next_pos++;
    end
    return r;
  endfunction

  // ---- result checker: oldest expectation against each taken result ----
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result value=%0d fend=%0b sat=%0b", $time,
                 filtered_value_o, frame_end_o, saturated_o);
        errors++;
      end else begin
        fir_out_t e;
        e = pending_q.pop_front();
        if (e.value !== filtered_value_o) begin
          $display("%0t: filtered_value exp %0d got %0d", $time, e.value, filtered_value_o);
          errors++;
        end
        if (e.fend !== frame_end_o) begin
          $display("%0t: frame_end exp %0b got %0b", $time, e.fend, frame_end_o);
          errors++;
        end
        if (e.sat !== saturated_o) begin
          $display("%0t: saturated exp %0b got %0b", $time, e.sat, saturated_o);
          errors++;
        end
      end
    end
  end

  // ---- receiver: random stalls, plus a long hold-off on request ----
  always @(negedge clk_i) begin
    if (hold_req && hold_left == 0) hold_left = 400;
    if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_req = 1'b0;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---- watchdog ----
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("temporal_fir_highpass_pixels verification failed");
      $finish;
    end
  end

  // Offer one item, honouring burst/gap pacing; predicts at acceptance
  task automatic send_pixel(logic signed [15:0] pix, output fir_out_t pred);
    if (burst_left == 0) begin
      int unsigned gap;
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    pixel_value_i <= pix;
    do @(posedge clk_i); while (in_stall_o);
    pred = fir_predict(pix);
    pending_q.push_back(pred);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every result is back, then let the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < CoeffRegs) coeff_words[idx] = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_pixel();
    case ($urandom_range(9))
      0:       return -16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return 16'(int'($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    // often shrink taps so results stay mostly in range
    if ($urandom_range(1))
      for (int j = 0; j < 4; j++) w[16*j +: 16] = 16'($signed(w[16*j +: 16]) >>> 4);
    return w;
  endfunction

  // directed table: reset coefficients, saturation both ways, rounding of halves,
  // largest positive tap, unit gain passing the extremes straight through
  row_t dir_rows [] = '{
    '{64'h0,    -16'sh8000, 1'b1,  16'sd0,     1'b0},
    '{64'h0,    16'sh7FFF,  1'b1,  16'sd0,     1'b0},
    '{64'h0,    16'sh0000,  1'b1,  16'sd0,     1'b0},
    '{64'h8000, -16'sh8000, 1'b1,  16'sh7FFF,  1'b1},
    '{64'h8000, 16'sh7FFF,  1'b1,  -16'sh8000, 1'b1},
    '{64'h8000, 16'sh0001,  1'b0,  16'sd0,     1'b0},
    '{64'h0001, 16'sd8192,  1'b1,  16'sd1,     1'b0},
    '{64'h0001, -16'sd8192, 1'b1,  16'sd0,     1'b0},
    '{64'h0001, 16'sd24576, 1'b1,  16'sd2,     1'b0},
    '{64'h0001, -16'sd24576,1'b1,  -16'sd1,    1'b0},
    '{64'h7FFF, 16'sh7FFF,  1'b1,  16'sh7FFF,  1'b1},
    '{64'h7FFF, -16'sh8000, 1'b0,  16'sd0,     1'b0},
    '{64'h4000, -16'sh8000, 1'b1,  -16'sh8000, 1'b0},
    '{64'h4000, 16'sh7FFF,  1'b1,  16'sh7FFF,  1'b0},
    '{64'h4000, 16'sh5555,  1'b1,  16'sh5555,  1'b0},
    '{64'h4000, -16'sd1,    1'b1,  -16'sd1,    1'b0}
  };

  initial begin
    fir_out_t pred;
    errors = 0; cycle_count = 0;
    gap_max = 0; burst_left = 0; stall_pct = 0;
    hold_req = 1'b0; hold_left = 0;
    for (int i = 0; i < CoeffRegs; i++) coeff_words[i] = '0;
    foreach (past_frames[i]) past_frames[i] = HistInit;
    next_pos = 0; newest_slot = 0;
    in_valid_i = 1'b0; pixel_value_i = '0; out_stall_i = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = RegCoeff03; cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, gaps and stalls light
    gap_max = 2; stall_pct = 20;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].taps03 !== coeff_words[0]) begin
        wait_idle();
        write_reg(RegCoeff03, dir_rows[i].taps03);
      end
      send_pixel(dir_rows[i].pixel, pred);
      if (dir_rows[i].typed &&
          (pred.value !== dir_rows[i].value || pred.sat !== dir_rows[i].sat)) begin
        $display("%0t: row %0d exp %0d/%0b got %0d/%0b", $time, i,
                 dir_rows[i].value, dir_rows[i].sat, pred.value, pred.sat);
        errors++;
      end
    end

    // random coefficient sets, extremes among them, unused index written too
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_reg(RegCoeff03, rand_word());
          write_reg(RegCoeff47, rand_word());
          write_reg(RegCoeff811, rand_word());
          write_reg(RegUnused, {$urandom, $urandom});
        end
        1: begin
          write_reg(RegCoeff03, {4{16'h7FFF}});
          write_reg(RegCoeff47, {4{16'h7FFF}});
          write_reg(RegCoeff811, {4{16'h7FFF}});
        end
        2: begin
          write_reg(RegCoeff03, {4{16'h8000}});
          write_reg(RegCoeff47, {4{16'h8000}});
          write_reg(RegCoeff811, {4{16'h8000}});
        end
        default: begin
          write_reg(RegCoeff03, rand_word());
          write_reg(RegCoeff47, rand_word());
          write_reg(RegCoeff811, {$urandom, $urandom});
        end
      endcase
      gap_max = (ph == 3) ? 0 : $urandom_range(6);
      stall_pct = (ph == 3) ? 0 : $urandom_range(60);
      for (int i = 0; i < 80; i++) begin
        if (ph == 0 && i == 40) hold_req = 1'b1;   // long hold-off, sender keeps going
        send_pixel(rand_pixel(), pred);
      end
    end

    // high-pass kernel, with a pause in the middle of the stream
    wait_idle();
    write_reg(RegCoeff03, {16'hFE00, 16'hFC00, 16'hF800, 16'h4000});
    write_reg(RegCoeff47, {16'hFF00, 16'hFF00, 16'hFE00, 16'hFE00});
    write_reg(RegCoeff811, {16'h1234, 16'h7FFF, 16'hFF80, 16'hFF80});
    gap_max = 1; stall_pct = 10;
    for (int i = 0; i < 80; i++) begin
      if (i == 40) begin
        // sender pauses until all results are back
        in_valid_i <= 1'b0;
        burst_left = 0;
        while (pending_q.size() != 0) @(negedge clk_i);
      end
      send_pixel(rand_pixel(), pred);
    end

    wait_idle();
    if (errors == 0 && pending_q.size() == 0) begin
      $display("temporal_fir_highpass_pixels verification clean");
    end else begin
      $display("temporal_fir_highpass_pixels verification failed");
    end
    $finish;
  end

endmodule
